// ===== design/bm3_pkg.sv =====
`timescale 1ns / 1ps

package bm3_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int DIM_W     = 11;                 // image_width / image_height registers
   localparam int ROW_W     = DIM_W + 1;          // row counter reaches height + 1
   localparam int CSR_DATA_W = DIM_W;
   localparam int CSR_IDX_W  = 2;

   localparam logic [DIM_W-1:0] MAX_WIDTH_DIM = DIM_W'(MAX_WIDTH);

   // register map
   localparam logic [CSR_IDX_W-1:0] REG_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 2'd3;

   localparam logic [8:0] SE_RESET   = 9'd186;
   localparam logic [8:0] COL_LEFT   = 9'h049;
   localparam logic [8:0] COL_RIGHT  = 9'h124;
   localparam logic [8:0] ROW_TOP    = 9'h007;
   localparam logic [8:0] ROW_BOTTOM = 9'h1C0;

   typedef enum logic [1:0] {
      MODE_ERODE  = 2'd0,
      MODE_DILATE = 2'd1,
      MODE_MATCH  = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } operation_type;

   typedef struct packed {
      logic operation;
      logic pixel_in;
   } req_payload_type;

   typedef struct packed {
      logic pixel_out;
      logic frame_last;
   } rsp_payload_type;

   // which window edges fall outside the image
   typedef struct packed {
      logic left;
      logic right;
      logic top;
      logic bottom;
   } edge_mask_type;

   // shift window one column left, new column enters on the right
   function automatic logic [8:0] shift_in(input logic [8:0] w, input logic top,
                                           input logic mid, input logic bot);
      logic [8:0] n;
      n    = (w >> 1) & 9'h0DB;
      n[2] = top;
      n[5] = mid;
      n[8] = bot;
      return n;
   endfunction

   function automatic logic [8:0] mirror9(input logic [8:0] m);
      logic [8:0] r;
      for (int k = 0; k < 9; k++) begin
         r[8-k] = m[k];
      end
      return r;
   endfunction

endpackage

// ===== design/binary_morphology_3x3.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Item
// req_      in         req_valid/req_stall  req_payload_type {operation, pixel_in}
// rsp_      out        rsp_valid/rsp_stall  rsp_payload_type {pixel_out, frame_last}
// csr_      in         csr_write_enable     csr_index, csr_data (no read-back)
//
// One item per clock, sustained while req_stall is low. Each item is evaluated in the cycle it is
// accepted and its result lands in the output register on that edge.
// The line-store RAM has a registered read, so the column the next item will
// use is prefetched every cycle; a same-address write is bypassed.
// Synchronous active-high reset clears counters, window and registers; the
// line store is not cleared (stale columns are always masked at the edges).
// req_stall is high only while a result sits in the output register and
// rsp_stall holds it there.

module binary_morphology_3x3
   import bm3_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,

   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // configuration
   mode_type         mode_ff;
   logic [8:0]       se_ff;
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;

   // raster position and 3x3 window
   logic [COL_W-1:0] column_ff, column_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [8:0]       window_ff, window_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             restart;
   logic             pix;
   logic [1:0]       store_rd;
   logic [DIM_W-1:0] w_eff;
   logic [DIM_W-1:0] h_eff;
   logic [ROW_W-1:0] h_plus1;
   logic [DIM_W-1:0] column_next;
   logic             col_zero;
   logic             in_frame;
   logic             last;
   logic [8:0]       eval;
   edge_mask_type    edges;
   logic             result;

   assign req_stall   = rsp_valid_ff && rsp_stall;
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // out-of-range geometry is clamped
   always_comb begin
      if (width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (width_ff > MAX_WIDTH_DIM) begin
         w_eff = MAX_WIDTH_DIM;
      end else begin
         w_eff = width_ff;
      end
      h_eff   = (height_ff == '0) ? DIM_W'(1) : height_ff;
      h_plus1 = {1'b0, h_eff} + ROW_W'(1);
   end

   // a flush counts as a zero pixel
   assign pix      = (req_payload.operation == OP_PIXEL) ? req_payload.pixel_in : 1'b0;
   assign col_zero = (column_ff == '0);

   // Column 0 finishes the previous row: its center is the last pixel two rows
   // back, with an empty column shifted in on the right.
   always_comb begin
      window_in = shift_in(window_ff, store_rd[1], store_rd[0], pix);
      if (col_zero) begin
         eval         = shift_in(window_ff, 1'b0, 1'b0, 1'b0);
         in_frame     = (row_ff >= ROW_W'(2)) && (row_ff <= h_plus1);
         edges.left   = (w_eff == DIM_W'(1));
         edges.right  = 1'b1;
         edges.top    = (row_ff == ROW_W'(2));
         edges.bottom = (row_ff == h_plus1);
      end else begin
         eval         = window_in;
         in_frame     = (row_ff >= ROW_W'(1)) && (row_ff <= {1'b0, h_eff});
         edges.left   = (column_ff == COL_W'(1));
         edges.right  = 1'b0;
         edges.top    = (row_ff == ROW_W'(1));
         edges.bottom = (row_ff == {1'b0, h_eff});
      end
      last = in_frame && col_zero && (row_ff == h_plus1);
   end

   bm3_kernel u_kernel (
      .window (eval),
      .edges  (edges),
      .mode   (mode_ff),
      .se     (se_ff),
      .result (result)
   );

   // next raster position; a geometry write or the frame's last result restarts
   assign restart     = csr_write_enable
                        && ((csr_index == REG_WIDTH) || (csr_index == REG_HEIGHT));
   assign column_next = {1'b0, column_ff} + DIM_W'(1);

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (restart) begin
         column_in = '0;
         row_in    = '0;
      end else if (accept) begin
         if (last) begin
            column_in = '0;
            row_in    = '0;
         end else if (column_next >= w_eff) begin
            column_in = '0;
            row_in    = row_ff + ROW_W'(1);
         end else begin
            column_in = column_next[COL_W-1:0];
         end
      end
   end

   // store shifts down one row at this column: {one row back, new pixel}
   bm3_line_ram u_line_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (column_ff),
      .wr_data ({store_rd[0], pix}),
      .rd_addr (column_in),
      .rd_data (store_rd)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept && in_frame) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.pixel_out  = result;
         rsp_data_in.frame_last = last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_ERODE;
         se_ff        <= SE_RESET;
         width_ff     <= DIM_W'(1024);
         height_ff    <= DIM_W'(1024);
         column_ff    <= '0;
         row_ff       <= '0;
         window_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_MODE:   mode_ff   <= mode_type'(csr_data[1:0]);
               REG_SE:     se_ff     <= csr_data[8:0];
               REG_WIDTH:  width_ff  <= csr_data;
               REG_HEIGHT: height_ff <= csr_data;
               default:    ;
            endcase
         end
         column_ff    <= column_in;
         row_ff       <= row_in;
         if (accept) begin
            window_ff <= window_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== design/bm3_line_ram.sv =====
`timescale 1ns / 1ps

module bm3_line_ram
   import bm3_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  logic [1:0]       wr_data,
   input  logic [COL_W-1:0] rd_addr,
   output logic [1:0]       rd_data
);

   // each entry: {pixel two rows back, pixel one row back}
   logic [1:0] mem [MAX_WIDTH];
   logic [1:0] rd_ff;
   logic [1:0] wr_data_ff;
   logic       bypass_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff      <= mem[rd_addr];
      wr_data_ff <= wr_data;
      bypass_ff  <= wr_en && (wr_addr == rd_addr);
   end

   // same-address write wins (e.g. single-column images)
   assign rd_data = bypass_ff ? wr_data_ff : rd_ff;

endmodule

// ===== design/bm3_kernel.sv =====
`timescale 1ns / 1ps

module bm3_kernel
   import bm3_pkg::*;
(
   input  logic [8:0]    window,
   input  edge_mask_type edges,
   input  mode_type      mode,
   input  logic [8:0]    se,
   output logic          result
);

   logic [8:0] nb;
   logic       center;

   always_comb begin
      nb = window;
      if (edges.left)   nb = nb & ~COL_LEFT;
      if (edges.right)  nb = nb & ~COL_RIGHT;
      if (edges.top)    nb = nb & ~ROW_TOP;
      if (edges.bottom) nb = nb & ~ROW_BOTTOM;
      center = nb[4];
      case (mode)
         MODE_ERODE:  result = center && ((nb & se) == se);
         MODE_DILATE: result = center || ((nb & mirror9(se)) != 9'd0);
         MODE_MATCH:  result = center && (nb == se);
         default:     result = 1'b0;
      endcase
   end

endmodule

// ===== bench/binary_morphology_3x3_test.sv =====
`timescale 1ns / 1ps

// Bench for the streaming 3x3 binary erode / dilate / match block.
// A directed table runs first: 1x1 frames whose single result can be read off
// by eye, every mode, both mask extremes, clamped geometry and pixels sent
// where a flush is due. Random frames follow, with broken frames, stray
// flushes and random idling on both sides.

module binary_morphology_3x3_test;
   import bm3_pkg::*;

   localparam bit ROW_ITEM  = 1'b0;
   localparam bit ROW_WRITE = 1'b1;
   localparam bit FREE      = 1'b0;   // expectation comes from the predictor
   localparam bit TYPED     = 1'b1;   // expectation typed into the row
   localparam int DIRECTED_ROWS = 40;
   localparam int RANDOM_ITEMS  = 900;
   localparam int SETTLE_CYCLES = 4;

   typedef struct {
      bit                    is_write;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
      operation_type         op;
      logic                  pixel;
      bit                    typed;
      rsp_payload_type       want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // no idling on either side while set
   bit calm = 1'b0;
   int mismatches = 0;

   // expected result items, oldest first
   rsp_payload_type pending_pixels[$];

   // predictor copy of the registers
   mode_type        cfg_mode;
   logic [8:0]      cfg_element;
   logic [DIM_W-1:0] cfg_width;
   logic [DIM_W-1:0] cfg_height;

   // predictor copy of the window state
   bit              upper_line [MAX_WIDTH];
   bit              lower_line [MAX_WIDTH];
   logic [8:0]      window;
   int              cur_col;
   int              cur_row;

   stim_row_type    directed_rows [DIRECTED_ROWS];

   binary_morphology_3x3 dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // width 0 acts as 1, anything past the line store acts as its depth
   function automatic int active_width();
      if (cfg_width == '0) return 1;
      if (int'(cfg_width) > MAX_WIDTH) return MAX_WIDTH;
      return int'(cfg_width);
   endfunction

   function automatic int active_height();
      return (cfg_height == '0) ? 1 : int'(cfg_height);
   endfunction

   // window moves one column left; the new column enters on the right
   function automatic logic [8:0] slide_window(input logic [8:0] w, input logic top,
                                               input logic mid, input logic bot);
      return {bot, w[8:7], mid, w[5:4], top, w[2:1]};
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] index,
                                          input logic [CSR_DATA_W-1:0] data);
      case (index)
         REG_MODE: begin
            cfg_mode = mode_type'(data[1:0]);
         end
         REG_SE: begin
            cfg_element = data[8:0];
         end
         REG_WIDTH, REG_HEIGHT: begin
            if (index == REG_WIDTH) cfg_width = data;
            else cfg_height = data;
            // geometry change starts a fresh frame, line stores are kept
            cur_col = 0;
            cur_row = 0;
         end
         default: begin
         end
      endcase
   endfunction

   // One accepted item in, at most one processed pixel out. The pixel that
   // comes out is centered one row plus one column behind the newest input.
   function automatic void compute_morph_pixel(input req_payload_type item,
                                               output rsp_payload_type pixel,
                                               output bit produced);
      int         w, h, x, y, r, c;
      logic       p, a, b, center, hit;
      logic [8:0] eval, nb, mirrored;
      w = active_width();
      h = active_height();
      x = cur_col;
      y = cur_row;
      // a flush counts as a 0 pixel
      p = (item.operation == OP_PIXEL) ? item.pixel_in : 1'b0;
      pixel = '0;
      produced = 1'b0;
      if (x >= w) x = 0;
      a = upper_line[x];
      b = lower_line[x];
      if (x == 0) begin
         // right-hand column of the last pixel in the previous row lies outside
         eval = slide_window(window, 1'b0, 1'b0, 1'b0);
         r = y - 2;
         c = w - 1;
      end else begin
         eval = slide_window(window, a, b, p);
         r = y - 1;
         c = x - 1;
      end
      window = slide_window(window, a, b, p);
      upper_line[x] = b;
      lower_line[x] = p;
      x++;
      if (x >= w) begin
         x = 0;
         y++;
      end
      cur_col = x;
      cur_row = y;
      // center still above the first row, or past the frame: nothing out
      if (r < 0 || r > h - 1) return;
      nb = eval;
      if (c == 0) nb &= ~COL_LEFT;
      if (c == w - 1) nb &= ~COL_RIGHT;
      if (r == 0) nb &= ~ROW_TOP;
      if (r == h - 1) nb &= ~ROW_BOTTOM;
      center = nb[4];
      // dilation probes pixel minus offset, so the element is mirrored
      for (int k = 0; k < 9; k++) mirrored[8-k] = cfg_element[k];
      case (cfg_mode)
         MODE_ERODE:  hit = center && ((nb & cfg_element) == cfg_element);
         MODE_DILATE: hit = center || ((nb & mirrored) != '0);
         MODE_MATCH:  hit = center && (nb == cfg_element);
         default:     hit = 1'b0;
      endcase
      pixel.pixel_out  = hit;
      pixel.frame_last = (r == h - 1) && (c == w - 1);
      produced = 1'b1;
      if (pixel.frame_last) begin
         cur_col = 0;
         cur_row = 0;
      end
   endfunction

   // queue one expected result item behind the others
   function automatic void expect_result(input rsp_payload_type item);
      pending_pixels = {pending_pixels, item};
   endfunction

   // Offer one item, with random idle cycles ahead of it, and wait until the
   // block takes it. req_valid stays high on return so back-to-back items do
   // not toggle it within one step.
   task automatic drive_item(input operation_type op, input logic pixel, input bit typed,
                             input rsp_payload_type want);
      rsp_payload_type got;
      bit              made;
      while (!calm && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{operation: op, pixel_in: pixel};
      do @(posedge clock); while (req_stall);
      compute_morph_pixel('{operation: op, pixel_in: pixel}, got, made);
      if (typed) expect_result(want);
      else if (made) expect_result(got);
   endtask

   // Hold the sender off until every expected item has come back, then let
   // the block settle.
   task automatic wait_for_drain(input int extra);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= data;
      @(posedge clock);
      apply_register(index, data);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // receiver: random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 14);
      end
   end

   // checker: every accepted result item against the oldest expectation
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected result item: pixel_out %0b frame_last %0b",
                   rsp_payload.pixel_out, rsp_payload.frame_last);
            mismatches++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_payload.pixel_out !== want.pixel_out) begin
               $error("pixel_out: expected %0b, got %0b", want.pixel_out,
                      rsp_payload.pixel_out);
               mismatches++;
            end
            if (rsp_payload.frame_last !== want.frame_last) begin
               $error("frame_last: expected %0b, got %0b", want.frame_last,
                      rsp_payload.frame_last);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int               random_items;
      int               phase;
      int               frames;
      int               w, h, cut, density;
      bit               pressure;
      operation_type    op;
      logic [8:0]       element;

      // predictor in its reset state
      cfg_mode    = MODE_ERODE;
      cfg_element = SE_RESET;
      cfg_width   = MAX_WIDTH_DIM;
      cfg_height  = MAX_WIDTH_DIM;
      window      = '0;
      cur_col     = 0;
      cur_row     = 0;
      for (int k = 0; k < MAX_WIDTH; k++) begin
         upper_line[k] = 1'b0;
         lower_line[k] = 1'b0;
      end

      // 1x1 frames: one pixel then two flushes, the third item brings out the
      // pixel with every neighbor outside the image and frame_last set
      directed_rows = '{
         // default 1024x1024 frame: first row gives nothing
         '{ROW_ITEM,  '0, '0, OP_PIXEL, 1'b1, FREE, 2'b00},
         '{ROW_ITEM,  '0, '0, OP_PIXEL, 1'b0, FREE, 2'b00},
         '{ROW_WRITE, REG_WIDTH,  11'd1, OP_PIXEL, 1'b0, FREE, 2'b00},
         '{ROW_WRITE, REG_HEIGHT, 11'd1, OP_PIXEL, 1'b0, FREE, 2'b00},
         '{ROW_WRITE, REG_MODE, CSR_DATA_W'(MODE_ERODE), OP_PIXEL, 1'b0, FREE, 2'b00},
         '{ROW_WRITE, REG_SE,   11'h010, OP_PIXEL, 1'b0, FREE, 2'b00},
         // erode, center-only element: pixel passes
         '{ROW_ITEM,  '0, '0, OP_PIXEL, 1'b1, FREE,  2'b00},
         '{ROW_ITEM,  '0, '0, OP_FLUSH, 1'b0, FREE,  2'b00},
         '{ROW_ITEM,  '0, '0, OP_FLUSH, 1'b1, TYPED, 2'b11},
         // erode, full element: outside neighbors kill it
         '{ROW_WRITE, REG_SE,   11'h1FF, OP_PIXEL, 1'b0, FREE, 2'b00},
         '{ROW_ITEM,  '0, '0, OP_PIXEL, 1'b1, FREE,  2'b00},
         '{ROW_ITEM,  '0, '0, OP_FLUSH, 1'b0, FREE,  2'b00},
         '{ROW_ITEM,  '0, '0, OP_FLUSH, 1'b1, TYPED, 2'b01},
         // dilate
         '{ROW_WRITE, REG_MODE, CSR_DATA_W'(MODE_DILATE), OP_PIXEL, 1'b0, FREE, 2'b00},
         '{ROW_ITEM,  '0, '0, OP_PIXEL, 1'b1, FREE,  2'b00},
         '{ROW_ITEM,  '0, '0, OP_FLUSH, 1'b1, FREE,  2'b00},
         '{ROW_ITEM,  '0, '0, OP_FLUSH, 1'b0, TYPED, 2'b11},
         // pixels where flushes are due act as flushes
         '{ROW_ITEM,  '0, '0, OP_PIXEL, 1'b0, FREE,  2'b00},
         '{ROW_ITEM,  '0, '0, OP_PIXEL, 1'b1, FREE,  2'b00},
         '{ROW_ITEM,  '0, '0, OP_PIXEL, 1'b1, TYPED, 2'b01},
         // exact match against center-only, then against the empty element
         '{ROW_WRITE, REG_MODE, CSR_DATA_W'(MODE_MATCH), OP_PIXEL, 1'b0, FREE, 2'b00},
         '{ROW_WRITE, REG_SE,   11'h010, OP_PIXEL, 1'b0, FREE, 2'b00},
         '{ROW_ITEM,  '0, '0, OP_PIXEL, 1'b1, FREE,  2'b00},
         '{ROW_ITEM,  '0, '0, OP_FLUSH, 1'b0, FREE,  2'b00},
         '{ROW_ITEM,  '0, '0, OP_FLUSH, 1'b0, TYPED, 2'b11},
         '{ROW_WRITE, REG_SE,   11'h000, OP_PIXEL, 1'b0, FREE, 2'b00},
         '{ROW_ITEM,  '0, '0, OP_PIXEL, 1'b1, FREE,  2'b00},
         '{ROW_ITEM,  '0, '0, OP_FLUSH, 1'b1, FREE,  2'b00},
         '{ROW_ITEM,  '0, '0, OP_FLUSH, 1'b1, TYPED, 2'b01},
         // unused mode always gives 0
         '{ROW_WRITE, REG_MODE, CSR_DATA_W'(MODE_UNUSED), OP_PIXEL, 1'b0, FREE, 2'b00},
         '{ROW_ITEM,  '0, '0, OP_PIXEL, 1'b1, FREE,  2'b00},
         '{ROW_ITEM,  '0, '0, OP_FLUSH, 1'b0, FREE,  2'b00},
         '{ROW_ITEM,  '0, '0, OP_FLUSH, 1'b0, TYPED, 2'b01},
         // zero width and height act as 1x1
         '{ROW_WRITE, REG_WIDTH,  11'd0, OP_PIXEL, 1'b0, FREE, 2'b00},
         '{ROW_WRITE, REG_HEIGHT, 11'd0, OP_PIXEL, 1'b0, FREE, 2'b00},
         '{ROW_WRITE, REG_MODE, CSR_DATA_W'(MODE_ERODE), OP_PIXEL, 1'b0, FREE, 2'b00},
         '{ROW_WRITE, REG_SE,   11'h010, OP_PIXEL, 1'b0, FREE, 2'b00},
         '{ROW_ITEM,  '0, '0, OP_PIXEL, 1'b1, FREE,  2'b00},
         '{ROW_ITEM,  '0, '0, OP_FLUSH, 1'b1, FREE,  2'b00},
         '{ROW_ITEM,  '0, '0, OP_FLUSH, 1'b0, TYPED, 2'b11}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].is_write) begin
            wait_for_drain(SETTLE_CYCLES);
            write_register(directed_rows[i].index, directed_rows[i].data);
         end else begin
            drive_item(directed_rows[i].op, directed_rows[i].pixel,
                       directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // Random phases: new geometry every phase, mode and element most of the
      // time. Most items are whole frames plus their drain, the rest noise.
      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         wait_for_drain(SETTLE_CYCLES);
         calm <= (phase == 4);
         if ($urandom_range(3) != 0 || phase == 0) begin
            // junk in the unused upper bits
            write_register(REG_MODE, {CSR_DATA_W'($urandom_range(0, 511)) << 2}
                                     | CSR_DATA_W'($urandom_range(0, 3)));
         end
         if ($urandom_range(3) != 0 || phase == 0) begin
            case ($urandom_range(0, 3))
               0:       element = 9'h000;
               1:       element = 9'h1FF;
               2:       element = SE_RESET;
               default: element = 9'($urandom_range(0, 511));
            endcase
            write_register(REG_SE, {2'($urandom_range(0, 3)), element});
         end
         write_register(REG_WIDTH, CSR_DATA_W'($urandom_range(0, 8)));
         write_register(REG_HEIGHT, CSR_DATA_W'($urandom_range(0, 6)));
         frames = $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            w = active_width();
            h = active_height();
            case ($urandom_range(0, 2))
               0:       density = 10;
               1:       density = 50;
               default: density = 90;
            endcase
            // now and then a frame is cut short
            cut = ($urandom_range(9) == 0) ? $urandom_range(1, w * h) : w * h;
            pressure = (phase == 1 && f == 0) || ($urandom_range(11) == 0);
            for (int i = 0; i < cut; i++) begin
               // stray flush inside the frame counts as a 0 pixel
               op = ($urandom_range(24) == 0) ? OP_FLUSH : OP_PIXEL;
               drive_item(op, 1'($urandom_range(99) < density), FREE, '0);
               if (pressure && i == cut / 2) wait_for_drain(1);
            end
            random_items += cut;
            if (cut == w * h) begin
               for (int i = 0; i <= w; i++) begin
                  op = ($urandom_range(19) == 0) ? OP_PIXEL : OP_FLUSH;
                  drive_item(op, 1'($urandom_range(0, 1)), FREE, '0);
               end
               random_items += w + 1;
            end
         end
         phase++;
      end

      wait_for_drain(8);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
